[hdl/assert_macros.svh]
// assertion macros shared by the rank/unrank rtl modules
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CRU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CRU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cru_pkg.sv]
// shared widths, constants and control/status structs for combination rank/unrank
// no dependencies; used by the interfaces, controller, datapath and top level
`default_nettype none

package cru_pkg;

  localparam int PAT_W     = 64;
  localparam int MAX_BITS  = PAT_W;
  localparam int RANK_W    = 61;
  localparam int CNT_W     = 7;
  localparam int ROW_W     = $clog2(MAX_BITS + 1);
  localparam int COL_W     = $clog2(MAX_BITS);
  localparam int MEM_DEPTH = (MAX_BITS + 1) * (2 ** COL_W);
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic [CNT_W-1:0] BIT_COUNT_RST = CNT_W'(MAX_BITS);

  // request codes
  localparam logic CMD_UNRANK = 1'b0;
  localparam logic CMD_RANK   = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic fill_rd;
    logic fill_wr;
    logic load;
    logic chk_rd;
    logic chk;
    logic step;
    logic emit;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic fill_last;
    logic chk_stop;
    logic step_last;
  } dp_stat_t;

endpackage

`default_nettype wire

[hdl/cru_in_if.sv]
// request channel interface: valid/ready plus request payload
// depends on cru_pkg for field widths
`default_nettype none

interface cru_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [cru_pkg::RANK_W-1:0]   rank_in;
  logic [cru_pkg::PAT_W-1:0]    pattern_in;
  logic [cru_pkg::CNT_W-1:0]    ones_count;

  modport source (output valid, cmd, rank_in, pattern_in, ones_count, input ready);
  modport sink   (input valid, cmd, rank_in, pattern_in, ones_count, output ready);
endinterface

`default_nettype wire

[hdl/cru_out_if.sv]
// result channel interface: valid/ready plus result payload
// depends on cru_pkg for field widths
`default_nettype none

interface cru_out_if;
  logic                         valid;
  logic                         ready;
  logic [cru_pkg::PAT_W-1:0]    pattern_out;
  logic [cru_pkg::RANK_W-1:0]   rank_out;
  logic                         error;

  modport source (output valid, pattern_out, rank_out, error, input ready);
  modport sink   (input valid, pattern_out, rank_out, error, output ready);
endinterface

`default_nettype wire

[hdl/combination_rank_unrank.sv]
// top level: combinatorial number system rank/unrank with fsm controller and datapath
// depends on cru_pkg, cru_in_if, cru_out_if, cru_ctrl and cru_dp
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in_if   | sink      | valid/ready        | cmd, rank_in, pattern_in, ones_count
//   out_if  | source    | valid/ready        | pattern_out, rank_out, error
//   cfg     | write     | cfg_we (no stall)  | cfg_wdata -> bit_count
//
// after reset the binomial memory is filled, a read state then a write state per entry, with in_ready low
// one transaction at a time: after accept come a check read, a check, s walk steps and the
// done state, where s is the number of walk steps (at most bit_count); each step is one
// registered read of the binomial memory plus one 61-bit compare and add/subtract
// transactions that fail the checks or have no ones to place skip the walk
// the result sits in an output register, so a new transaction is taken while it waits;
// that next one then holds in its done state, with in_ready low, until the slot frees
`default_nettype none

module combination_rank_unrank (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [cru_pkg::CNT_W-1:0] cfg_wdata,
  cru_in_if.sink                    in_if,
  cru_out_if.source                 out_if
);

  // command/status between controller and datapath
  cru_pkg::ctl_cmd_t cmd;
  cru_pkg::dp_stat_t stat;

  logic in_ready;
  logic out_valid;

  // fsm: fill sequencing, then idle/check/walk/done per transaction
  cru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .out_ready (out_if.ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

  // binomial memory, bit_count register, walk registers, result register
  cru_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .stat        (stat),
    .in_cmd      (in_if.cmd),
    .in_rank     (in_if.rank_in),
    .in_pattern  (in_if.pattern_in),
    .in_ones     (in_if.ones_count),
    .out_pattern (out_if.pattern_out),
    .out_rank    (out_if.rank_out),
    .out_error   (out_if.error)
  );

endmodule

`default_nettype wire

[hdl/cru_ctrl.sv]
// controller fsm: table fill sequencing, per-transaction walk control, output valid
// depends on cru_pkg (command/status structs) and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cru_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_ready,
  output logic              in_ready,
  output logic              out_valid,
  output cru_pkg::ctl_cmd_t cmd,
  input  cru_pkg::dp_stat_t stat
);

  typedef enum logic [2:0] {
    ST_FILL_RD,
    ST_FILL_WR,
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_FILL_RD: begin
        cmd.fill_rd = 1'b1;
        state_nxt   = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        cmd.fill_wr = 1'b1;
        state_nxt   = stat.fill_last ? ST_IDLE : ST_FILL_RD;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHK_RD;
        end
      end
      ST_CHK_RD: begin
        cmd.chk_rd = 1'b1;
        state_nxt  = ST_CHK;
      end
      ST_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = stat.chk_stop ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (stat.step_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_FILL_RD;
      end
    endcase
  end

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL_RD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CRU_ASSERT_IMP(a_emit_needs_slot, cmd.emit, !out_valid_r || out_ready, "result overwritten")
  `CRU_ASSERT_NXT(a_one_in_flight, accept, !in_ready, "second transaction taken while busy")
  `CRU_ASSERT_IMP(a_valid_from_done, $rose(out_valid_r), $past(state_r == ST_DONE), "stray valid")

endmodule

`default_nettype wire

[hdl/cru_dp.sv]
// datapath: binomial memory with fill, request registers, compare/add/subtract walk
// depends on cru_pkg (widths, codes, structs) and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cru_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cru_pkg::CNT_W-1:0]   cfg_wdata,
  input  cru_pkg::ctl_cmd_t           cmd,
  output cru_pkg::dp_stat_t           stat,
  input  logic                        in_cmd,
  input  logic [cru_pkg::RANK_W-1:0]  in_rank,
  input  logic [cru_pkg::PAT_W-1:0]   in_pattern,
  input  logic [cru_pkg::CNT_W-1:0]   in_ones,
  output logic [cru_pkg::PAT_W-1:0]   out_pattern,
  output logic [cru_pkg::RANK_W-1:0]  out_rank,
  output logic                        out_error
);

  // binomial memory, row-major: address = {row, column}
  logic [cru_pkg::RANK_W-1:0] binom_mem [0:cru_pkg::MEM_DEPTH-1];
  logic [cru_pkg::RANK_W-1:0] rd_a_r, rd_b_r;

  logic [cru_pkg::CNT_W-1:0]  bit_count_r;
  logic [cru_pkg::ROW_W-1:0]  fill_row_r;
  logic [cru_pkg::COL_W-1:0]  fill_col_r;

  logic                       cmd_r;
  logic [cru_pkg::RANK_W-1:0] acc_r;
  logic [cru_pkg::PAT_W-1:0]  pat_r;
  logic [cru_pkg::CNT_W-1:0]  ones_r;
  logic [cru_pkg::CNT_W-1:0]  k_r, k_nxt;
  logic [cru_pkg::CNT_W-1:0]  rem_r;
  logic [cru_pkg::PAT_W-1:0]  mask_r;
  logic [cru_pkg::PAT_W-1:0]  pout_r;
  logic                       err_r;

  logic [cru_pkg::PAT_W-1:0]  out_pattern_r;
  logic [cru_pkg::RANK_W-1:0] out_rank_r;
  logic                       out_error_r;

  logic                       n_bad, ones_over, rank_over, stray, chk_err, take;
  logic [cru_pkg::RANK_W-1:0] binom_nk, wr_val;
  logic [cru_pkg::PAT_W-1:0]  vmask;
  logic [cru_pkg::ROW_W-1:0]  row_sel;
  logic [cru_pkg::COL_W-1:0]  col_sel;
  logic [cru_pkg::ADDR_W-1:0] addr_a, addr_b, wr_addr;

  // rows above the last one are never needed; park them on entry zero
  function automatic logic [cru_pkg::ADDR_W-1:0] tab_addr(
    input logic [cru_pkg::ROW_W-1:0] row,
    input logic [cru_pkg::COL_W-1:0] col
  );
    if (row > cru_pkg::ROW_W'(cru_pkg::MAX_BITS)) begin
      tab_addr = '0;
    end else begin
      tab_addr = {row, col};
    end
  endfunction

  // request checks
  assign n_bad     = (bit_count_r == '0) || (bit_count_r > cru_pkg::CNT_W'(cru_pkg::MAX_BITS));
  assign binom_nk  = (ones_r >= cru_pkg::CNT_W'(cru_pkg::MAX_BITS))
                   ? cru_pkg::RANK_W'(bit_count_r == cru_pkg::CNT_W'(cru_pkg::MAX_BITS))
                   : rd_a_r;
  assign ones_over = ones_r > bit_count_r;
  assign rank_over = acc_r >= binom_nk;
  assign vmask     = (bit_count_r >= cru_pkg::CNT_W'(cru_pkg::MAX_BITS)) ? {cru_pkg::PAT_W{1'b1}}
                   : ~({cru_pkg::PAT_W{1'b1}} << bit_count_r[cru_pkg::COL_W-1:0]);
  assign stray     = |(pat_r & ~vmask);
  assign chk_err   = n_bad || ((cmd_r == cru_pkg::CMD_RANK) ? stray : (ones_over || rank_over));

  // one walk step
  assign take  = (cmd_r == cru_pkg::CMD_RANK) ? pat_r[0] : (acc_r < rd_a_r);
  assign k_nxt = take ? (k_r - cru_pkg::CNT_W'(1)) : k_r;

  // read port a address
  always_comb begin
    row_sel = '0;
    col_sel = '0;
    if (cmd.fill_rd) begin
      row_sel = fill_row_r - cru_pkg::ROW_W'(1);
      col_sel = fill_col_r - cru_pkg::COL_W'(1);
    end else if (cmd.chk_rd) begin
      row_sel = cru_pkg::ROW_W'(bit_count_r);
      col_sel = ones_r[cru_pkg::COL_W-1:0];
    end else if (cmd.chk) begin
      row_sel = cru_pkg::ROW_W'(bit_count_r - cru_pkg::CNT_W'(1));
      col_sel = cru_pkg::COL_W'(k_r - cru_pkg::CNT_W'(1));
    end else if (cmd.step) begin
      row_sel = cru_pkg::ROW_W'(rem_r - cru_pkg::CNT_W'(2));
      col_sel = cru_pkg::COL_W'(k_nxt - cru_pkg::CNT_W'(1));
    end
  end

  assign addr_a  = tab_addr(row_sel, col_sel);
  assign addr_b  = tab_addr(fill_row_r - cru_pkg::ROW_W'(1), fill_col_r);
  assign wr_addr = {fill_row_r, fill_col_r};

  // pascal rule, row zero seeded directly
  always_comb begin
    if (fill_row_r == '0) begin
      wr_val = cru_pkg::RANK_W'(fill_col_r == '0);
    end else begin
      wr_val = ((fill_col_r == '0) ? '0 : rd_a_r) + rd_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_wr) begin
      binom_mem[wr_addr] <= wr_val;
    end
    rd_a_r <= binom_mem[addr_a];
    rd_b_r <= binom_mem[addr_b];
  end

  assign stat.fill_last = (fill_row_r == cru_pkg::ROW_W'(cru_pkg::MAX_BITS))
                       && (fill_col_r == '1);
  assign stat.chk_stop  = chk_err || (k_r == '0);
  assign stat.step_last = (rem_r == cru_pkg::CNT_W'(1)) || (k_nxt == '0);

  // config register and fill counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r <= cru_pkg::BIT_COUNT_RST;
      fill_row_r  <= '0;
      fill_col_r  <= '0;
    end else begin
      if (cfg_we) begin
        bit_count_r <= cfg_wdata;
      end
      if (cmd.fill_wr) begin
        fill_col_r <= fill_col_r + cru_pkg::COL_W'(1);
        if (fill_col_r == '1) begin
          fill_row_r <= fill_row_r + cru_pkg::ROW_W'(1);
        end
      end
    end
  end

  // request and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      acc_r  <= (in_cmd == cru_pkg::CMD_RANK) ? '0 : in_rank;
      pat_r  <= in_pattern;
      ones_r <= in_ones;
    end
    if (cmd.chk_rd) begin
      k_r <= (cmd_r == cru_pkg::CMD_RANK) ? cru_pkg::CNT_W'($countones(pat_r)) : ones_r;
    end
    if (cmd.chk) begin
      err_r  <= chk_err;
      rem_r  <= bit_count_r;
      mask_r <= cru_pkg::PAT_W'(1);
      pout_r <= '0;
    end
    if (cmd.step) begin
      if (take) begin
        pout_r <= pout_r | mask_r;
      end else begin
        acc_r <= (cmd_r == cru_pkg::CMD_RANK) ? (acc_r + rd_a_r) : (acc_r - rd_a_r);
      end
      k_r    <= k_nxt;
      rem_r  <= rem_r - cru_pkg::CNT_W'(1);
      pat_r  <= pat_r >> 1;
      mask_r <= mask_r << 1;
    end
    if (cmd.emit) begin
      out_pattern_r <= (err_r || (cmd_r == cru_pkg::CMD_RANK)) ? '0 : pout_r;
      out_rank_r    <= (err_r || (cmd_r == cru_pkg::CMD_UNRANK)) ? '0 : acc_r;
      out_error_r   <= err_r;
    end
  end

  assign out_pattern = out_pattern_r;
  assign out_rank    = out_rank_r;
  assign out_error   = out_error_r;

  `CRU_ASSERT_IMP(a_ones_fit_rest, cmd.step, k_r <= rem_r, "more ones left than positions")

endmodule

`default_nettype wire

[tb/combination_rank_unrank_checker.sv]
`timescale 1ns / 100ps
// result checker for combination_rank_unrank: watches the request, result and cfg ports
// predicts every result from its own binomial table and compares it field by field
// depends on cru_pkg and the cru_in_if / cru_out_if interfaces
module combination_rank_unrank_checker
  import cru_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  cru_in_if                req_mon,
  cru_out_if               res_mon,
  output int               fail_count,
  output int               outstanding,
  output int               results_checked
);

  typedef struct packed {
    logic [PAT_W-1:0]  pattern;
    logic [RANK_W-1:0] rank;
    logic              error;
  } walk_result_t;

  logic [63:0]  binom_lut [0:MAX_BITS][0:MAX_BITS];
  logic [CNT_W-1:0] n_positions;
  walk_result_t walk_results_q[$];
  walk_result_t want;
  int           fails   = 0;
  int           checked = 0;
  int           pending = 0;

  assign fail_count      = fails;
  assign outstanding     = pending;
  assign results_checked = checked;

  initial begin
    for (int r = 0; r <= MAX_BITS; r++) begin
      for (int c = 0; c <= MAX_BITS; c++) begin
        if (c > r) begin
          binom_lut[r][c] = '0;
        end else if (c == 0 || c == r) begin
          binom_lut[r][c] = 64'd1;
        end else begin
          binom_lut[r][c] = binom_lut[r-1][c-1] + binom_lut[r-1][c];
        end
      end
    end
  end

  function automatic logic [63:0] binom_at(int r, int c);
    if (r < 0 || c < 0 || r > MAX_BITS || c > r) return '0;
    return binom_lut[r][c];
  endfunction

  // walks positions from bit 0 up, same order as the hardware
  function automatic walk_result_t expected_walk(logic cmd, logic [RANK_W-1:0] rank_i,
                                                 logic [PAT_W-1:0] pat_i,
                                                 logic [CNT_W-1:0] ones_i,
                                                 logic [CNT_W-1:0] n_i);
    walk_result_t res;
    logic [63:0]  left, acc, mask, step_b;
    int           n, k;
    res  = '0;
    n    = n_i;
    k    = ones_i;
    left = 64'(rank_i);
    if (n == 0 || n > MAX_BITS) begin
      res.error = 1'b1;
    end else if (cmd == CMD_UNRANK) begin
      if (k > n || left >= binom_at(n, k)) begin
        res.error = 1'b1;
      end else begin
        for (int pos = 0; pos < n && k > 0; pos++) begin
          step_b = binom_at(n - pos - 1, k - 1);
          if (left < step_b) begin
            res.pattern[pos] = 1'b1;
            k--;
          end else begin
            left -= step_b;
          end
        end
      end
    end else begin
      mask = (n >= 64) ? '1 : (64'd1 << n) - 64'd1;
      if ((pat_i & ~mask) != '0) begin
        res.error = 1'b1;
      end else begin
        k   = $countones(pat_i);
        acc = '0;
        for (int pos = 0; pos < n && k > 0; pos++) begin
          if (pat_i[pos]) k--;
          else acc += binom_at(n - pos - 1, k - 1);
        end
        res.rank = acc[RANK_W-1:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("[%0t] mismatch on %s: got %h, want %h", $time, field, got, exp_val);
    fails++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      n_positions = BIT_COUNT_RST;
      walk_results_q.delete();
    end else begin
      if (cfg_we) n_positions = cfg_wdata;
      if (res_mon.valid && res_mon.ready) begin
        if (walk_results_q.size() == 0) begin
          report_mismatch("unexpected result", res_mon.pattern_out, '0);
        end else begin
          want = walk_results_q.pop_front();
          if (res_mon.pattern_out !== want.pattern)
            report_mismatch("pattern_out", res_mon.pattern_out, want.pattern);
          if (res_mon.rank_out !== want.rank)
            report_mismatch("rank_out", 64'(res_mon.rank_out), 64'(want.rank));
          if (res_mon.error !== want.error)
            report_mismatch("error", 64'(res_mon.error), 64'(want.error));
          checked++;
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        // queue the prediction at the tail
        walk_results_q.insert(walk_results_q.size(),
                              expected_walk(req_mon.cmd, req_mon.rank_in,
                                            req_mon.pattern_in, req_mon.ones_count,
                                            n_positions));
      end
    end
    pending <= walk_results_q.size();
  end

endmodule

[tb/combination_rank_unrank_tb.sv]
`timescale 1ns / 100ps
// top of the combination_rank_unrank testbench: clock, reset, request and result traffic
// depends on cru_pkg, cru_in_if, cru_out_if, the block and combination_rank_unrank_checker
module combination_rank_unrank_tb;
  import cru_pkg::*;

  localparam int NUM_PHASES    = 11;
  localparam int LONG_HOLD     = 400;   // cycles the result side holds off once
  localparam int SETTLE_CYCLES = 100;   // quiet time at the end to catch stray results

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  int mismatches;
  int outstanding;
  int compared;

  // traffic shaping, set by the stimulus process, read by both sides
  int idle_pct;
  bit calm;
  bit hold_req;

  int requests_sent    = 0;
  int settings_written = 0;

  // bit_count per random phase; the last one is replaced by a random legal count
  int phase_bits [NUM_PHASES] = '{64, 1, 2, 17, 0, 40, 127, 63, 65, 64, 64};
  int idle_levels [3]         = '{0, 15, 40};

  cru_in_if  req_if ();
  cru_out_if res_if ();

  combination_rank_unrank i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (req_if),
    .out_if    (res_if)
  );

  combination_rank_unrank_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .req_mon         (req_if),
    .res_mon         (res_if),
    .fail_count      (mismatches),
    .outstanding     (outstanding),
    .results_checked (compared)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // number of n-bit patterns with k ones, used only to aim ranks at the legal range
  function automatic logic [63:0] subset_total(int n, int k);
    logic [127:0] acc;
    if (k < 0 || k > n) return '0;
    acc = 128'd1;
    for (int i = 0; i < k; i++) acc = acc * (n - i) / (i + 1);
    return acc[63:0];
  endfunction

  // offer one transaction, optionally after an idle burst, and hold it until taken
  task automatic offer_request(input logic cmd, input logic [RANK_W-1:0] rank,
                               input logic [PAT_W-1:0] pat, input logic [CNT_W-1:0] ones);
    int gap;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 15);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.cmd        <= cmd;
    req_if.rank_in    <= rank;
    req_if.pattern_in <= pat;
    req_if.ones_count <= ones;
    do @(posedge clk); while (!req_if.ready);
    requests_sent++;
  endtask

  // the unused fields carry junk so that the block has to ignore them
  task automatic unrank_req(input logic [RANK_W-1:0] rank, input logic [CNT_W-1:0] ones);
    offer_request(CMD_UNRANK, rank, rand64(), ones);
  endtask

  task automatic rank_req(input logic [PAT_W-1:0] pat);
    offer_request(CMD_RANK, RANK_W'(rand64()), pat, CNT_W'($urandom()));
  endtask

  // drop valid and wait until every transaction has come back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // the register is only written with the block idle
  task automatic write_bit_count(input logic [CNT_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  task automatic random_request(input int n);
    logic [63:0] span, mask, pat;
    int          k, pick;
    pick = $urandom_range(0, 99);
    if (n == 0 || n > MAX_BITS) begin
      // bad bit count: anything goes, all of it must come back as an error
      if (pick < 50) unrank_req(RANK_W'(rand64()), CNT_W'($urandom()));
      else rank_req(rand64());
    end else begin
      mask = (n >= 64) ? '1 : (64'd1 << n) - 64'd1;
      if (pick < 45) begin
        // legal unrank, a few at zero ones and at all ones
        k    = (pick < 5) ? (pick[0] ? n : 0) : $urandom_range(0, n);
        span = subset_total(n, k);
        unrank_req(RANK_W'(rand64() % span), CNT_W'(k));
      end else if (pick < 88) begin
        // legal rank with mixed densities of ones
        case ($urandom_range(0, 3))
          0: begin
            pat = rand64() & rand64();
          end
          1: begin
            pat = rand64() | rand64();
          end
          2: begin
            pat = rand64() & rand64() & rand64();
          end
          default: begin
            pat = rand64();
          end
        endcase
        rank_req(pat & mask);
      end else if (pick < 91) begin
        // rank at or just past the number of patterns
        k = $urandom_range(0, n);
        unrank_req(RANK_W'(subset_total(n, k) + $urandom_range(0, 1000)), CNT_W'(k));
      end else if (pick < 94) begin
        // more ones asked for than there are positions
        unrank_req(RANK_W'(rand64()), CNT_W'($urandom_range(n + 1, 127)));
      end else if (n < 64) begin
        // stray bit at or above bit_count
        rank_req((rand64() & mask) | (64'd1 << $urandom_range(n, 63)));
      end else begin
        rank_req(rand64());
      end
    end
  endtask

  // result side: random stall bursts, plus one long hold-off so the block backs up
  initial begin : result_sink
    int stall_left;
    bit held;
    stall_left = 0;
    held       = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held       = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < idle_pct / 3) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [63:0] span;
    int          n, reps;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    req_if.valid      <= 1'b0;
    req_if.cmd        <= CMD_UNRANK;
    req_if.rank_in    <= '0;
    req_if.pattern_in <= '0;
    req_if.ones_count <= '0;
    idle_pct          <= 0;
    calm              <= 1'b0;
    hold_req          <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n    <= 1'b1;
    idle_pct <= 20;

    // directed part at the reset bit_count of 64; the first transaction also
    // waits out the binomial table fill
    span = subset_total(64, 32);
    unrank_req('0, 7'd0);                      // zero ones gives the empty pattern
    rank_req('0);                              // empty pattern ranks to zero
    unrank_req('0, 7'd64);                     // every bit set
    rank_req('1);
    unrank_req(RANK_W'(span - 64'd1), 7'd32);  // largest rank of the widest row
    unrank_req(RANK_W'(span), 7'd32);          // one past it: rank too large
    unrank_req('0, 7'd65);                     // more ones than positions
    unrank_req('1, 7'd127);
    unrank_req(RANK_W'(63), 7'd1);             // single one lands on bit 63
    rank_req(64'h8000_0000_0000_0000);
    rank_req(64'hAAAA_AAAA_AAAA_AAAA);
    unrank_req('1, 7'd32);                     // top of the rank field

    // narrowest legal width
    write_bit_count(7'd1);
    unrank_req('0, 7'd0);
    unrank_req('0, 7'd1);
    unrank_req(RANK_W'(1), 7'd1);              // rank too large
    unrank_req('0, 7'd2);                      // too many ones
    rank_req(64'd1);
    rank_req(64'd2);                           // stray bit above the width
    rank_req('0);

    // illegal widths: both commands must report an error
    write_bit_count(7'd0);
    unrank_req('0, 7'd0);
    rank_req('0);
    write_bit_count(7'd127);
    rank_req('0);
    unrank_req('0, 7'd0);

    // random phases across several widths, with varying idle levels;
    // the first phase also holds the result side off for a long stretch
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      n = (ph == NUM_PHASES - 1) ? $urandom_range(1, MAX_BITS) : phase_bits[ph];
      write_bit_count(CNT_W'(n));
      idle_pct <= idle_levels[ph % 3];
      calm     <= (ph == NUM_PHASES - 1);
      if (ph == 0) hold_req <= 1'b1;
      reps = (n == 0 || n > MAX_BITS) ? 15 : 60;
      repeat (reps) random_request(n);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("summary: %0d transactions sent over %0d register writes, %0d results compared",
             requests_sent, settings_written, compared);
    $display("summary: widths 0, 1, 2, 17, 40, 63, 64, 65, 127 and one random legal width");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, well above the slowest legal run including the table fill
  initial begin : watchdog
    #5ms;
    $display("timeout with %0d results outstanding", outstanding);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[combination_rank_unrank.f]
+incdir+hdl
hdl/cru_pkg.sv
hdl/cru_in_if.sv
hdl/cru_out_if.sv
hdl/cru_ctrl.sv
hdl/cru_dp.sv
hdl/combination_rank_unrank.sv
tb/combination_rank_unrank_checker.sv
tb/combination_rank_unrank_tb.sv
